>>> rtl/tfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfm_pkg
// Shared types, constants and helpers of the tiered fuzzy text match scorer.
// ----------------------------------------------------------------------------
package tfm_pkg;

   localparam int QueryMax   = 32;
   localparam int QIdxW      = $clog2(QueryMax);
   localparam int QLenW      = 6;
   localparam int TextMax    = 256;
   localparam int PosW       = $clog2(TextMax + 1);
   localparam int ChW        = 8;
   localparam int ScoreW     = 13;
   localparam int TierW      = 3;
   localparam int RunW       = 6;
   localparam int CsrW       = 64;
   localparam int CsrIdxW    = 3;
   localparam int QueryRegs  = 4;
   localparam int QueryBits  = QueryRegs * CsrW;

   localparam int ScoreEmpty  = 1;
   localparam int ScoreEqual  = 420;
   localparam int ScorePrefix = 340;
   localparam int PrefixCap   = 80;
   localparam int ScoreSubstr = 260;
   localparam int SubstrStep  = 3;
   localparam int ScoreFuzzy  = 140;
   localparam int FuzzyBase   = 18;
   localparam int FuzzyMin    = 2;
   localparam int RunBonus    = 5;
   localparam int FuzzyGapCap = (FuzzyBase - FuzzyMin) / 2;

   localparam logic [CsrIdxW-1:0] RegQuery0   = 3'd0;
   localparam logic [CsrIdxW-1:0] RegQuery1   = 3'd1;
   localparam logic [CsrIdxW-1:0] RegQuery2   = 3'd2;
   localparam logic [CsrIdxW-1:0] RegQuery3   = 3'd3;
   localparam logic [CsrIdxW-1:0] RegQueryLen = 3'd4;

   typedef enum logic [TierW-1:0] {
      TierEmpty  = 3'd0,
      TierEqual  = 3'd1,
      TierPrefix = 3'd2,
      TierSubstr = 3'd3,
      TierFuzzy  = 3'd4,
      TierNone   = 3'd5
   } tier_type;

   // per-request step control broadcast to the cell row
   typedef struct packed {
      logic           consume;
      logic           restart;
      logic [ChW-1:0] ch;
   } step_type;

   // text state captured on the closing request
   typedef struct packed {
      logic [PosW-1:0]   trimmed;
      logic              found;
      logic [PosW-1:0]   first_index;
      logic              fuzzy_done;
      logic [ScoreW-1:0] fuzzy_score;
   } snap_type;

   function automatic logic [ChW-1:0] to_lower(input logic [ChW-1:0] c);
      logic [ChW-1:0] r;
      r = c;
      if (c >= 8'd65 && c <= 8'd90) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

   function automatic logic is_space(input logic [ChW-1:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   endfunction

endpackage

>>> rtl/tfm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfm_cell
// One shift-and cell: holds a single partial-match bit for one query slot.
// ----------------------------------------------------------------------------
module tfm_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  tfm_pkg::step_type          step,
   input  logic [tfm_pkg::ChW-1:0]    q_char,
   input  logic                       active,
   input  logic                       prev_bit,
   output logic                       match_in,
   output logic                       match_ff
);

   always_comb begin
      match_in = match_ff;
      if (step.consume) begin
         match_in = prev_bit & active & (q_char == step.ch);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || step.restart) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

endmodule

>>> rtl/tfm_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfm_track
// Text position, trimming, substring detection and greedy fuzzy state.
// ----------------------------------------------------------------------------
module tfm_track (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [tfm_pkg::ChW-1:0]         raw_ch,
   input  logic                            has_byte,
   input  logic                            last_byte,
   input  logic [tfm_pkg::QueryBits-1:0]   query,
   input  logic [tfm_pkg::QLenW-1:0]       qlen,
   input  logic [tfm_pkg::QueryMax-1:0]    match_in,
   output tfm_pkg::step_type               step,
   output tfm_pkg::snap_type               snap
);

   logic                            lead_ff, lead_in;
   logic [tfm_pkg::PosW-1:0]        pos_ff, pos_in;
   logic [tfm_pkg::PosW-1:0]        trim_ff, trim_in;
   logic                            found_ff, found_in;
   logic [tfm_pkg::PosW-1:0]        fmi_ff, fmi_in;
   logic [tfm_pkg::QLenW-1:0]       fqi_ff, fqi_in;
   logic [tfm_pkg::PosW-1:0]        fsp_ff, fsp_in;
   logic [tfm_pkg::ScoreW-1:0]      fsc_ff, fsc_in;
   logic [tfm_pkg::RunW-1:0]        run_ff, run_in;

   logic [tfm_pkg::ChW-1:0]         ch;
   logic                            take, consume, hit;
   logic [tfm_pkg::QIdxW-1:0]       last_slot;
   logic [tfm_pkg::PosW-1:0]        gap;
   logic [tfm_pkg::ScoreW-1:0]      add;

   assign ch        = tfm_pkg::to_lower(raw_ch);
   assign take      = accept && has_byte && !(lead_ff && tfm_pkg::is_space(ch));
   assign consume   = take && (pos_ff < tfm_pkg::PosW'(tfm_pkg::TextMax));
   assign last_slot = tfm_pkg::QIdxW'(qlen - tfm_pkg::QLenW'(1));
   assign gap       = pos_ff - fsp_ff;
   assign hit       = consume && (fqi_ff < qlen)
                      && (ch == query[fqi_ff[tfm_pkg::QIdxW-1:0] * tfm_pkg::ChW +: tfm_pkg::ChW]);

   assign step.consume = consume;
   assign step.restart = accept && last_byte;
   assign step.ch      = ch;

   always_comb begin
      lead_in  = lead_ff;
      pos_in   = pos_ff;
      trim_in  = trim_ff;
      found_in = found_ff;
      fmi_in   = fmi_ff;
      fqi_in   = fqi_ff;
      fsp_in   = fsp_ff;
      fsc_in   = fsc_ff;
      run_in   = run_ff;
      add      = tfm_pkg::ScoreW'(tfm_pkg::FuzzyMin);
      if (take) begin
         lead_in = 1'b0;
      end
      if (consume) begin
         pos_in = pos_ff + tfm_pkg::PosW'(1);
         if (!tfm_pkg::is_space(ch)) begin
            trim_in = pos_ff + tfm_pkg::PosW'(1);
         end
         // query fully matched ending at this byte
         if (qlen != '0 && !found_ff && match_in[last_slot]) begin
            found_in = 1'b1;
            fmi_in   = pos_ff + tfm_pkg::PosW'(1) - tfm_pkg::PosW'(qlen);
         end
         if (hit) begin
            if (gap < tfm_pkg::PosW'(tfm_pkg::FuzzyGapCap)) begin
               add = tfm_pkg::ScoreW'(tfm_pkg::FuzzyBase) - (tfm_pkg::ScoreW'(gap) << 1);
            end
            run_in = (gap == '0) ? run_ff + tfm_pkg::RunW'(1) : '0;
            fsc_in = fsc_ff + add
                     + tfm_pkg::ScoreW'(run_in) * tfm_pkg::ScoreW'(tfm_pkg::RunBonus);
            fsp_in = pos_ff + tfm_pkg::PosW'(1);
            fqi_in = fqi_ff + tfm_pkg::QLenW'(1);
         end
      end
   end

   assign snap.trimmed     = trim_in;
   assign snap.found       = found_in;
   assign snap.first_index = fmi_in;
   assign snap.fuzzy_done  = (fqi_in == qlen);
   assign snap.fuzzy_score = fsc_in;

   always_ff @(posedge clock) begin
      if (reset || step.restart) begin
         lead_ff  <= 1'b1;
         pos_ff   <= '0;
         trim_ff  <= '0;
         found_ff <= 1'b0;
         fmi_ff   <= '0;
         fqi_ff   <= '0;
         fsp_ff   <= '0;
         fsc_ff   <= '0;
         run_ff   <= '0;
      end else begin
         lead_ff  <= lead_in;
         pos_ff   <= pos_in;
         trim_ff  <= trim_in;
         found_ff <= found_in;
         fmi_ff   <= fmi_in;
         fqi_ff   <= fqi_in;
         fsp_ff   <= fsp_in;
         fsc_ff   <= fsc_in;
         run_ff   <= run_in;
      end
   end

endmodule

>>> rtl/tiered_fuzzy_text_match_scorer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiered_fuzzy_text_match_scorer
// Scores a streamed candidate text against a configured query.
// ----------------------------------------------------------------------------
// Takes one text byte per clock, back to back, as long as the result side
// keeps up. Each byte steps a row of 32 shift-and cells and the position and
// fuzzy trackers. The request carrying tlast produces one result: the
// closing text state is captured into the snapshot register, and from there
// the tier and score are picked into the result register. Text state is
// cleared by that same request, so the next text may follow immediately.
// The query must only be rewritten while no text is in flight.
module tiered_fuzzy_text_match_scorer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] text_byte
   input  logic                           req_tuser,   // [0] has_byte
   input  logic                           req_tlast,   // last_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [15:0]                    rsp_tdata,   // [12:0] match_score, zero fill
   output logic [3:0]                     rsp_tuser,   // [0] matched, [3:1] match_tier
   input  logic                           csr_we,
   input  logic [tfm_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [tfm_pkg::CsrW-1:0]       csr_wdata
);

   logic [tfm_pkg::QueryBits-1:0]   query_ff;
   logic [tfm_pkg::QLenW-1:0]       qlen_reg_ff;
   logic [tfm_pkg::QLenW-1:0]       qlen;

   logic                            accept;
   tfm_pkg::step_type               step;
   tfm_pkg::snap_type               snap_in, snap_ff;
   logic                            snap_valid_ff;
   logic                            out_free;

   logic [tfm_pkg::QueryMax-1:0]    match_in, match_ff;

   logic                            rsp_valid_ff;
   logic                            matched_ff, matched_in;
   logic [tfm_pkg::ScoreW-1:0]      score_ff, score_in;
   tfm_pkg::tier_type               tier_ff, tier_in;
   logic [tfm_pkg::PosW-1:0]        diff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         query_ff    <= '0;
         qlen_reg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            tfm_pkg::RegQuery0:   query_ff[0 * tfm_pkg::CsrW +: tfm_pkg::CsrW] <= csr_wdata;
            tfm_pkg::RegQuery1:   query_ff[1 * tfm_pkg::CsrW +: tfm_pkg::CsrW] <= csr_wdata;
            tfm_pkg::RegQuery2:   query_ff[2 * tfm_pkg::CsrW +: tfm_pkg::CsrW] <= csr_wdata;
            tfm_pkg::RegQuery3:   query_ff[3 * tfm_pkg::CsrW +: tfm_pkg::CsrW] <= csr_wdata;
            tfm_pkg::RegQueryLen: qlen_reg_ff <= csr_wdata[tfm_pkg::QLenW-1:0];
            default: ;
         endcase
      end
   end

   assign qlen = (qlen_reg_ff > tfm_pkg::QLenW'(tfm_pkg::QueryMax))
                 ? tfm_pkg::QLenW'(tfm_pkg::QueryMax) : qlen_reg_ff;

   // pipeline handshake
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !snap_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   tfm_track u_track (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .raw_ch    (req_tdata),
      .has_byte  (req_tuser),
      .last_byte (req_tlast),
      .query     (query_ff),
      .qlen      (qlen),
      .match_in  (match_in),
      .step      (step),
      .snap      (snap_in)
   );

   for (genvar i = 0; i < tfm_pkg::QueryMax; i++) begin : g_cell
      logic prev_bit;
      if (i == 0) begin : g_head
         assign prev_bit = 1'b1;
      end else begin : g_link
         assign prev_bit = match_ff[i-1];
      end
      tfm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .step     (step),
         .q_char   (query_ff[i * tfm_pkg::ChW +: tfm_pkg::ChW]),
         .active   (tfm_pkg::QLenW'(i) < qlen),
         .prev_bit (prev_bit),
         .match_in (match_in[i]),
         .match_ff (match_ff[i])
      );
   end

   // capture closing text state
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (accept && req_tlast) begin
         snap_valid_ff <= 1'b1;
      end else if (out_free) begin
         snap_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_tlast) begin
         snap_ff <= snap_in;
      end
   end

   // tier select; all arithmetic modulo 2^13, results stay within range
   always_comb begin
      matched_in = 1'b0;
      tier_in    = tfm_pkg::TierNone;
      score_in   = '0;
      diff       = snap_ff.trimmed - tfm_pkg::PosW'(qlen);
      if (qlen == '0) begin
         matched_in = 1'b1;
         tier_in    = tfm_pkg::TierEmpty;
         score_in   = tfm_pkg::ScoreW'(tfm_pkg::ScoreEmpty);
      end else if (snap_ff.trimmed == '0) begin
         tier_in = tfm_pkg::TierNone;
      end else if (snap_ff.found && snap_ff.first_index == '0) begin
         matched_in = 1'b1;
         if (snap_ff.trimmed == tfm_pkg::PosW'(qlen)) begin
            tier_in  = tfm_pkg::TierEqual;
            score_in = tfm_pkg::ScoreW'(tfm_pkg::ScoreEqual);
         end else begin
            tier_in = tfm_pkg::TierPrefix;
            // trailing-space query may leave trimmed text shorter than query
            if (snap_ff.trimmed < tfm_pkg::PosW'(qlen)
                || diff > tfm_pkg::PosW'(tfm_pkg::PrefixCap)) begin
               score_in = tfm_pkg::ScoreW'(tfm_pkg::ScorePrefix - tfm_pkg::PrefixCap);
            end else begin
               score_in = tfm_pkg::ScoreW'(tfm_pkg::ScorePrefix) - tfm_pkg::ScoreW'(diff);
            end
         end
      end else if (snap_ff.found) begin
         matched_in = 1'b1;
         tier_in    = tfm_pkg::TierSubstr;
         score_in   = tfm_pkg::ScoreW'(tfm_pkg::ScoreSubstr)
                      - tfm_pkg::ScoreW'(snap_ff.first_index)
                        * tfm_pkg::ScoreW'(tfm_pkg::SubstrStep);
      end else if (snap_ff.fuzzy_done) begin
         matched_in = 1'b1;
         tier_in    = tfm_pkg::TierFuzzy;
         score_in   = tfm_pkg::ScoreW'(tfm_pkg::ScoreFuzzy) + snap_ff.fuzzy_score;
         if (snap_ff.trimmed > tfm_pkg::PosW'(qlen)) begin
            score_in = score_in - tfm_pkg::ScoreW'(diff);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= snap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && snap_valid_ff) begin
         matched_ff <= matched_in;
         score_ff   <= score_in;
         tier_ff    <= tier_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, score_ff};
   assign rsp_tuser  = {tier_ff, matched_ff};

`ifndef SYNTHESIS
   a_snap_held: assert property (@(posedge clock) disable iff (reset)
      snap_valid_ff && !out_free |=> snap_valid_ff)
      else $error("captured text state dropped while result stalled");

   a_cells_cleared: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> match_ff == '0)
      else $error("shift-and cells not cleared after closing request");

   a_matched_tier: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (matched_ff == (tier_ff != tfm_pkg::TierNone)))
      else $error("matched flag disagrees with tier");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && tier_ff == tfm_pkg::TierNone |-> score_ff == '0)
      else $error("nonzero score without a match");

   a_empty_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && tier_ff == tfm_pkg::TierEmpty
         |-> score_ff == tfm_pkg::ScoreW'(tfm_pkg::ScoreEmpty))
      else $error("empty query score wrong");
`endif

endmodule

>>> sim/tb_tiered_fuzzy_text_match_scorer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tiered_fuzzy_text_match_scorer
// Self-checking bench for the tiered fuzzy text match scorer.
// ----------------------------------------------------------------------------
// Streams candidate texts against a series of queries, mirrors the scoring
// tiers (empty query, equal, prefix, substring, fuzzy, none) in a local
// predictor and checks every result in order. Directed texts walk the tiers
// and the odd inputs, random texts are built around the current query, both
// sides stall at random, and one long result-side hold-off backs up the block.
// ----------------------------------------------------------------------------
module tb_tiered_fuzzy_text_match_scorer;

   localparam int QuietLimit  = 4000;
   localparam int DrainCycles = 8;
   localparam int HoldCycles  = 300;
   localparam int MaxShown    = 30;
   localparam int ScoreLow    = -1024;
   localparam int ScoreHigh   = 4095;

   typedef logic [7:0] text_type [$];
   typedef logic [tfm_pkg::QueryBits-1:0] query_image_type;   // query byte i at [8*i +: 8]

   typedef struct packed {
      logic                       matched;
      logic [tfm_pkg::ScoreW-1:0] score;
      tfm_pkg::tier_type          tier;
   } verdict_type;

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [7:0]                   req_tdata  = '0;
   logic                         req_tuser  = 1'b0;
   logic                         req_tlast  = 1'b0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [15:0]                  rsp_tdata;
   logic [3:0]                   rsp_tuser;
   logic                         csr_we     = 1'b0;
   logic [tfm_pkg::CsrIdxW-1:0]  csr_index  = '0;
   logic [tfm_pkg::CsrW-1:0]     csr_wdata  = '0;

   // mirrored registers
   logic [tfm_pkg::CsrW-1:0]     qry_word [tfm_pkg::QueryRegs] = '{default: '0};
   logic [tfm_pkg::QLenW-1:0]    qry_len_reg = '0;

   // mirrored text state
   logic                txt_lead   = 1'b1;
   int                  txt_pos    = 0;
   int                  txt_trim   = 0;
   logic [31:0]         shift_bits = '0;
   int                  sub_first  = 0;
   logic                sub_found  = 1'b0;
   int                  fz_idx     = 0;
   int                  fz_pos     = 0;
   int                  fz_score   = 0;
   int                  fz_run     = 0;

   verdict_type         pending_verdicts [$];

   int                  send_idle_pct  = 0;
   int                  rsp_idle_pct   = 0;
   int                  rsp_hold_req   = 0;
   int                  hold_left      = 0;
   bit                  scatter_blanks = 1'b0;
   int                  quiet_cycles   = 0;
   int                  errors         = 0;
   int                  requests_sent  = 0;
   int                  texts_sent     = 0;
   int                  query_settings = 0;
   int                  results_seen   = 0;
   int                  tier_hits [6]  = '{default: 0};

   tiered_fuzzy_text_match_scorer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int active_len();
      // the row is 32 cells wide, longer lengths clip
      return (qry_len_reg > tfm_pkg::QueryMax) ? tfm_pkg::QueryMax : int'(qry_len_reg);
   endfunction

   function automatic logic [7:0] query_char(input int i);
      return qry_word[i / 8][(i % 8) * 8 +: 8];
   endfunction

   function automatic logic blank_char(input logic [7:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic void mirror_csr(input logic [tfm_pkg::CsrIdxW-1:0] idx,
                                      input logic [tfm_pkg::CsrW-1:0] value);
      if (idx < tfm_pkg::RegQueryLen) begin
         qry_word[idx] = value;
      end else if (idx == tfm_pkg::RegQueryLen) begin
         qry_len_reg = value[tfm_pkg::QLenW-1:0];
      end
   endfunction

   function automatic void clear_text_state();
      txt_lead   = 1'b1;
      txt_pos    = 0;
      txt_trim   = 0;
      shift_bits = '0;
      sub_first  = 0;
      sub_found  = 1'b0;
      fz_idx     = 0;
      fz_pos     = 0;
      fz_score   = 0;
      fz_run     = 0;
   endfunction

   function automatic void fold_text_byte(input logic [7:0] raw);
      logic [7:0]  c;
      logic [31:0] hits;
      int          n, p, i, gain;
      c = raw;
      if (c >= 8'd65 && c <= 8'd90) c = c + 8'd32;
      n = active_len();
      p = txt_pos;
      hits = '0;
      for (i = 0; i < n; i++) begin
         if (query_char(i) == c) hits[i] = 1'b1;
      end
      shift_bits = ((shift_bits << 1) | 32'd1) & hits;
      if (n > 0 && !sub_found && shift_bits[n-1]) begin
         sub_found = 1'b1;
         sub_first = p + 1 - n;
      end
      // greedy subsequence: take the next query char at its first occurrence
      if (fz_idx < n && c == query_char(fz_idx)) begin
         gain = tfm_pkg::FuzzyBase - 2 * (p - fz_pos);
         if (gain < tfm_pkg::FuzzyMin) gain = tfm_pkg::FuzzyMin;
         fz_run   = (p == fz_pos) ? fz_run + 1 : 0;
         fz_score = fz_score + gain + tfm_pkg::RunBonus * fz_run;
         fz_pos   = p + 1;
         fz_idx   = fz_idx + 1;
      end
      if (!blank_char(c)) txt_trim = p + 1;
      txt_pos = p + 1;
   endfunction

   function automatic verdict_type close_text();
      verdict_type v;
      int          n, s, d;
      n = active_len();
      v.matched = 1'b0;
      v.tier    = tfm_pkg::TierNone;
      s = 0;
      if (n == 0) begin
         v.matched = 1'b1;
         v.tier    = tfm_pkg::TierEmpty;
         s = tfm_pkg::ScoreEmpty;
      end else if (txt_trim != 0) begin
         if (sub_found && sub_first == 0) begin
            v.matched = 1'b1;
            if (txt_trim == n) begin
               v.tier = tfm_pkg::TierEqual;
               s = tfm_pkg::ScoreEqual;
            end else begin
               // a trimmed text shorter than the query counts as a full cap
               d = txt_trim - n;
               if (d < 0 || d > tfm_pkg::PrefixCap) d = tfm_pkg::PrefixCap;
               v.tier = tfm_pkg::TierPrefix;
               s = tfm_pkg::ScorePrefix - d;
            end
         end else if (sub_found) begin
            v.matched = 1'b1;
            v.tier    = tfm_pkg::TierSubstr;
            s = tfm_pkg::ScoreSubstr - tfm_pkg::SubstrStep * sub_first;
         end else if (fz_idx == n) begin
            d = txt_trim - n;
            if (d < 0) d = 0;
            v.matched = 1'b1;
            v.tier    = tfm_pkg::TierFuzzy;
            s = tfm_pkg::ScoreFuzzy + fz_score - d;
         end
      end
      if (s < ScoreLow) s = ScoreLow;
      else if (s > ScoreHigh) s = ScoreHigh;
      v.score = s[tfm_pkg::ScoreW-1:0];
      clear_text_state();
      return v;
   endfunction

   function automatic void apply_request(input logic [7:0] data, input logic has,
                                         input logic last);
      if (has && !(txt_lead && blank_char(data))) begin
         txt_lead = 1'b0;
         if (txt_pos < tfm_pkg::TextMax) fold_text_byte(data);
      end
      if (last) pending_verdicts.insert(pending_verdicts.size(), close_text());
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_field(input string what, input logic signed [15:0] want,
                                       input logic signed [15:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= MaxShown) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         end
      end
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tuser[3:1] <= tfm_pkg::TierNone) tier_hits[rsp_tuser[3:1]]++;
         if (pending_verdicts.size() == 0) begin
            errors++;
            if (errors <= MaxShown) begin
               $display("%0t ns: result with none expected, expected nothing, actual score %0d tier %0d",
                        $time, $signed(rsp_tdata[12:0]), rsp_tuser[3:1]);
            end
         end else begin
            want = pending_verdicts.pop_front();
            check_field("matched", want.matched, rsp_tuser[0]);
            check_field("match_score", $signed(want.score), $signed(rsp_tdata[12:0]));
            check_field("match_tier", want.tier, rsp_tuser[3:1]);
            check_field("score padding", 0, rsp_tdata[15:13]);
         end
      end
   end

   // ends the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
         $display("%0t ns: timeout, %0d results outstanding", $time, pending_verdicts.size());
         $display("tb_tiered_fuzzy_text_match_scorer: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stalls plus an optional long hold-off
   always @(negedge clock) begin
      if (rsp_hold_req != 0) begin
         hold_left = rsp_hold_req;
         rsp_hold_req = 0;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // ---------------------------------------------------------------- drivers

   // called and returns at a falling edge; tvalid stays high on return
   task automatic send_request(input logic [7:0] data, input logic has, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= has;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_request(data, has, last);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input text_type t, input bit blank_end);
      int i;
      for (i = 0; i < t.size(); i++) begin
         if (scatter_blanks && $urandom_range(15) == 0) begin
            send_request(8'($urandom_range(255)), 1'b0, 1'b0);
         end
         send_request(t[i], 1'b1, !blank_end && i == t.size() - 1);
      end
      // closing request without a byte
      if (blank_end || t.size() == 0) send_request(8'($urandom_range(255)), 1'b0, 1'b1);
      texts_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [tfm_pkg::CsrIdxW-1:0] idx,
                            input logic [tfm_pkg::CsrW-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      mirror_csr(idx, value);
      @(negedge clock);
   endtask

   task automatic set_query(input query_image_type img, input int len_code,
                            input bit poke_spare);
      int idx;
      wait_idle();
      write_csr(tfm_pkg::RegQuery0, img[0 * tfm_pkg::CsrW +: tfm_pkg::CsrW]);
      write_csr(tfm_pkg::RegQuery1, img[1 * tfm_pkg::CsrW +: tfm_pkg::CsrW]);
      write_csr(tfm_pkg::RegQuery2, img[2 * tfm_pkg::CsrW +: tfm_pkg::CsrW]);
      write_csr(tfm_pkg::RegQuery3, img[3 * tfm_pkg::CsrW +: tfm_pkg::CsrW]);
      if (poke_spare) begin
         for (idx = tfm_pkg::RegQueryLen + 1; idx < (1 << tfm_pkg::CsrIdxW); idx++) begin
            write_csr(idx[tfm_pkg::CsrIdxW-1:0], {$urandom, $urandom});
         end
      end
      write_csr(tfm_pkg::RegQueryLen, tfm_pkg::CsrW'(len_code));
      csr_we <= 1'b0;
      query_settings++;
   endtask

   task automatic set_idle(input int send_pct, input int rsp_pct);
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
   endtask

   // ---------------------------------------------------------------- text builders

   function automatic void add_byte(ref text_type t, input logic [7:0] b);
      t.insert(t.size(), b);
   endfunction

   function automatic text_type str_bytes(input string s);
      text_type t;
      int       i;
      for (i = 0; i < s.len(); i++) add_byte(t, s[i]);
      return t;
   endfunction

   function automatic query_image_type pad_query(input string s);
      query_image_type img;
      int              i;
      for (i = 0; i < tfm_pkg::QueryMax; i++) begin
         img[i * 8 +: 8] = (i < s.len()) ? s[i] : 8'($urandom_range(255));
      end
      return img;
   endfunction

   function automatic logic [7:0] blank_byte();
      int k;
      k = $urandom_range(6);
      return (k == 6) ? 8'd32 : 8'(9 + k);
   endfunction

   function automatic logic [7:0] filler_byte();
      int k;
      k = $urandom_range(15);
      if (k < 10) return 8'(97 + $urandom_range(4));
      if (k < 13) return 8'(65 + $urandom_range(4));
      if (k < 14) return blank_byte();
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] shift_case(input logic [7:0] c);
      if (c >= 8'd97 && c <= 8'd122 && $urandom_range(3) == 0) return c - 8'd32;
      return c;
   endfunction

   // mostly texts shaped around the query: exact, prefix, substring, scattered
   function automatic text_type random_text();
      text_type t;
      int       n, i, k, kind, tail;
      n = active_len();
      kind = $urandom_range(5);
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) add_byte(t, blank_byte());
      if (kind == 2) repeat ($urandom_range(1, 6)) add_byte(t, filler_byte());
      if (kind <= 2) begin
         for (i = 0; i < n; i++) add_byte(t, shift_case(query_char(i)));
      end else if (kind == 3) begin
         for (i = 0; i < n; i++) begin
            add_byte(t, shift_case(query_char(i)));
            if ($urandom_range(2) == 0) repeat ($urandom_range(1, 3)) add_byte(t, filler_byte());
         end
      end else if (kind == 4) begin
         repeat ($urandom_range(12)) add_byte(t, filler_byte());
      end else begin
         repeat ($urandom_range(12)) add_byte(t, 8'($urandom_range(255)));
      end
      if (kind == 1 || kind == 2) begin
         k = $urandom_range(29);
         tail = (k == 0) ? $urandom_range(80, 120) :
                (k == 1) ? $urandom_range(260, 300) : $urandom_range(1, 6);
         repeat (tail) add_byte(t, filler_byte());
      end
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) add_byte(t, blank_byte());
      return t;
   endfunction

   task automatic new_random_query();
      query_image_type img;
      int              i, k, len_code;
      bit              odd;
      odd = ($urandom_range(7) == 0);
      for (i = 0; i < tfm_pkg::QueryMax; i++) begin
         if (odd && $urandom_range(3) == 0) begin
            // untrimmed or upper-case query characters
            img[i * 8 +: 8] = $urandom_range(1) ? blank_byte() : 8'(65 + $urandom_range(3));
         end else begin
            img[i * 8 +: 8] = 8'(97 + $urandom_range(3));
         end
      end
      k = $urandom_range(15);
      if (k == 0) img = '1;
      else if (k == 1) img = '0;
      k = $urandom_range(19);
      len_code = (k == 0) ? 0 : (k == 1) ? tfm_pkg::QueryMax :
                 (k == 2) ? $urandom_range(tfm_pkg::QueryMax + 1, (1 << tfm_pkg::QLenW) - 1)
                          : $urandom_range(1, 6);
      set_query(img, len_code, $urandom_range(3) == 0);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_empty_query();
      // registers are still at reset: empty query scores every text
      send_text(str_bytes("ab"), 1'b0);
      send_text(str_bytes(""), 1'b1);
   endtask

   task automatic test_tier_ladder();
      text_type odd_bytes;
      set_query(pad_query("abc"), 3, 1'b0);
      send_text(str_bytes("abc"), 1'b0);
      send_text(str_bytes(" \tABC\r "), 1'b0);
      send_text(str_bytes("abcd"), 1'b0);
      send_text(str_bytes("xabc"), 1'b0);
      send_text(str_bytes("axbc"), 1'b0);
      send_text(str_bytes("cba"), 1'b0);
      send_text(str_bytes(""), 1'b1);
      send_text(str_bytes("  \n"), 1'b0);
      // request without a byte in the middle of a text
      send_request("a", 1'b1, 1'b0);
      send_request("b", 1'b1, 1'b0);
      send_request(8'hff, 1'b0, 1'b0);
      send_request("c", 1'b1, 1'b1);
      texts_sent++;
      odd_bytes = str_bytes("");
      add_byte(odd_bytes, 8'hff);
      add_byte(odd_bytes, 8'h00);
      send_text(odd_bytes, 1'b0);
   endtask

   task automatic test_query_forms();
      // query bytes compare as written, no folding or trimming
      set_query(pad_query(" Ab"), 3, 1'b1);
      send_text(str_bytes("x ab"), 1'b0);
      // oversize length clips to the full row
      set_query(pad_query("abcdefghijklmnopqrstuvwxyz012345"), (1 << tfm_pkg::QLenW) - 1, 1'b1);
      send_text(str_bytes("x"), 1'b0);
   endtask

   task automatic test_long_text();
      text_type t;
      set_query(pad_query("ab"), 2, 1'b0);
      repeat (3) add_byte(t, 8'd32);
      repeat (250) add_byte(t, "z");
      add_byte(t, "a");
      add_byte(t, "b");
      repeat (10) add_byte(t, "q");
      send_text(t, 1'b0);
      // match sits past the saturation point
      t = str_bytes("");
      repeat (300) add_byte(t, "z");
      add_byte(t, "a");
      add_byte(t, "b");
      send_text(t, 1'b1);
   endtask

   task automatic test_result_backpressure();
      set_query(pad_query("ab"), 2, 1'b0);
      @(posedge clock);
      rsp_hold_req = HoldCycles;
      @(negedge clock);
      repeat (15) begin
         send_text(str_bytes("ab"), 1'b0);
         send_text(str_bytes("xab"), 1'b0);
         send_text(str_bytes("aXb"), 1'b0);
      end
   endtask

   task automatic run_random_phase(input int budget);
      int first;
      first = requests_sent;
      scatter_blanks = 1'b1;
      while (requests_sent - first < budget) begin
         new_random_query();
         repeat ($urandom_range(4, 10)) send_text(random_text(), $urandom_range(3) == 0);
      end
      scatter_blanks = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_idle(7, 72);
      test_empty_query();
      test_tier_ladder();
      test_query_forms();
      test_long_text();
      test_result_backpressure();
      run_random_phase(400);
      set_idle(72, 7);
      run_random_phase(400);
      set_idle(0, 0);
      run_random_phase(400);
      wait_idle();
      $display("run covered %0d requests in %0d texts over %0d query settings, %0d results",
               requests_sent, texts_sent, query_settings, results_seen);
      $display("tiers seen: empty %0d equal %0d prefix %0d substring %0d fuzzy %0d none %0d",
               tier_hits[tfm_pkg::TierEmpty], tier_hits[tfm_pkg::TierEqual],
               tier_hits[tfm_pkg::TierPrefix], tier_hits[tfm_pkg::TierSubstr],
               tier_hits[tfm_pkg::TierFuzzy], tier_hits[tfm_pkg::TierNone]);
      if (errors == 0) begin
         $display("tb_tiered_fuzzy_text_match_scorer: clean");
      end else begin
         $display("tb_tiered_fuzzy_text_match_scorer: errors");
      end
      $finish;
   end

endmodule
